@@ design/polygon_area_with_holes_top_macros.svh @@
// Assertion macros shared by the polygon area modules.
// Each expects clk and rst_n to be visible where it is used.
`ifndef POLYGON_AREA_WITH_HOLES_TOP_MACROS_SVH
`define POLYGON_AREA_WITH_HOLES_TOP_MACROS_SVH

// same-cycle implication
`define PAHW_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define PAHW_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ design/pahw_pkg.sv @@
// Shared widths, word layout, pipeline tag type and overflow helpers
// for the polygon area block. No dependencies.
package pahw_pkg;

  localparam int COORD_BITS = 24;
  localparam int FIELD_W    = 24;
  localparam int PROD_W     = 2 * COORD_BITS;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int ACC_W      = 64;
  localparam int IN_DATA_W  = 2 * FIELD_W;
  localparam int IN_USER_W  = 3;

  localparam int UB_RING_END = 0;
  localparam int UB_IS_HOLE  = 1;
  localparam int UB_IS_POLY  = 2;

  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic start;
    logic close;
    logic hole;
    logic gend;
    logic poly;
  } pahw_tag_t;

  function automatic logic signed [COORD_BITS-1:0] coord_of(input logic [FIELD_W-1:0] f);
    logic [31:0] z;
    z = 32'(f);
    return z[COORD_BITS-1:0];
  endfunction

  function automatic logic add_ovf(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b,
                                   input logic [ACC_W-1:0] s);
    return (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
  endfunction

  function automatic logic sub_ovf(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b,
                                   input logic [ACC_W-1:0] s);
    return (a[ACC_W-1] != b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
  endfunction

endpackage

@@ design/pahw_vertex.sv @@
// Vertex stage: first/previous vertex tracking and the four shoelace products.
// Depends on pahw_pkg.
`include "polygon_area_with_holes_top_macros.svh"

module pahw_vertex import pahw_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         v_in,
  input  logic signed [COORD_BITS-1:0] x_in,
  input  logic signed [COORD_BITS-1:0] y_in,
  input  pahw_tag_t                    tag_in,
  output logic                         v_out,
  output logic signed [PROD_W-1:0]     pa_out,
  output logic signed [PROD_W-1:0]     pb_out,
  output logic signed [PROD_W-1:0]     pc_out,
  output logic signed [PROD_W-1:0]     pd_out,
  output pahw_tag_t                    tag_out
);

  logic signed [COORD_BITS-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [COORD_BITS-1:0] first_x_nxt, first_y_nxt;
  logic                         start_r;
  logic                         v_r;
  logic signed [PROD_W-1:0]     pa_r, pb_r, pc_r, pd_r;
  logic signed [PROD_W-1:0]     pa_nxt, pb_nxt, pc_nxt, pd_nxt;
  pahw_tag_t                    tag_r, tag_nxt;

  always_comb begin
    first_x_nxt   = start_r ? x_in : first_x_r;
    first_y_nxt   = start_r ? y_in : first_y_r;
    pa_nxt        = prev_x_r * y_in;
    pb_nxt        = x_in * prev_y_r;
    pc_nxt        = x_in * first_y_nxt;
    pd_nxt        = first_x_nxt * y_in;
    tag_nxt       = tag_in;
    tag_nxt.start = start_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= 1'b0;
      start_r   <= 1'b1;
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
    end else if (en) begin
      v_r <= v_in;
      if (v_in) begin
        start_r   <= tag_in.close;
        first_x_r <= first_x_nxt;
        first_y_r <= first_y_nxt;
        prev_x_r  <= x_in;
        prev_y_r  <= y_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= pa_nxt;
      pb_r  <= pb_nxt;
      pc_r  <= pc_nxt;
      pd_r  <= pd_nxt;
      tag_r <= tag_nxt;
    end
  end

  assign v_out   = v_r;
  assign pa_out  = pa_r;
  assign pb_out  = pb_r;
  assign pc_out  = pc_r;
  assign pd_out  = pd_r;
  assign tag_out = tag_r;

  `PAHW_ASSERT_NXT(a_close_rearms, en && v_in && tag_in.close, start_r, "ring close did not rearm start")
  `PAHW_ASSERT_NXT(a_start_tagged, en && v_in && start_r, tag_r.start, "ring start lost in tag")

endmodule

@@ design/pahw_ring.sv @@
// Ring stage: cross terms, then the per-ring running sum with closing term.
// Depends on pahw_pkg.
`include "polygon_area_with_holes_top_macros.svh"

module pahw_ring import pahw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     v_in,
  input  logic signed [PROD_W-1:0] pa_in,
  input  logic signed [PROD_W-1:0] pb_in,
  input  logic signed [PROD_W-1:0] pc_in,
  input  logic signed [PROD_W-1:0] pd_in,
  input  pahw_tag_t                tag_in,
  output logic                     v_out,
  output logic [ACC_W-1:0]         ring_out,
  output logic                     ovf_out,
  output pahw_tag_t                tag_out
);

  logic                      v3_r, v4_r;
  logic signed [CROSS_W-1:0] c1_r, c2_r;
  pahw_tag_t                 tag3_r, tag4_r;
  logic [ACC_W-1:0]          ring_acc_r, ring_acc_nxt;
  logic [ACC_W-1:0]          t1, t2, sum1, sum2;
  logic                      ovf1, ovf2;
  logic [ACC_W-1:0]          tot_r;
  logic                      ovf_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r   <= CROSS_W'(pa_in) - CROSS_W'(pb_in);
      c2_r   <= CROSS_W'(pc_in) - CROSS_W'(pd_in);
      tag3_r <= tag_in;
    end
  end

  always_comb begin
    t1   = ACC_W'(c1_r);
    t2   = ACC_W'(c2_r);
    sum1 = tag3_r.start ? '0 : ring_acc_r + t1;
    ovf1 = !tag3_r.start && add_ovf(ring_acc_r, t1, sum1);
    sum2 = sum1 + t2;
    ovf2 = tag3_r.close && add_ovf(sum1, t2, sum2);
    ring_acc_nxt = tag3_r.close ? '0 : sum1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      ring_acc_r <= '0;
    end else if (en) begin
      v3_r <= v_in;
      v4_r <= v3_r;
      if (v3_r) begin
        ring_acc_r <= ring_acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tot_r  <= sum2;
      ovf_r  <= ovf1 | ovf2;
      tag4_r <= tag3_r;
    end
  end

  assign v_out    = v4_r;
  assign ring_out = tot_r;
  assign ovf_out  = ovf_r;
  assign tag_out  = tag4_r;

  `PAHW_ASSERT_NXT(a_ring_clears, en && v3_r && tag3_r.close, ring_acc_r == '0, "ring sum not cleared")
  `PAHW_ASSERT_NXT(a_start_no_ovf, en && v3_r && tag3_r.start && !tag3_r.close, !ovf_r, "overflow on ring start")

endmodule

@@ design/pahw_geom.sv @@
// Geometry stage: ring magnitude, outer/hole total, overflow and result register.
// Depends on pahw_pkg.
`include "polygon_area_with_holes_top_macros.svh"

module pahw_geom import pahw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             v_in,
  input  logic [ACC_W-1:0] ring_in,
  input  logic             ovf_in,
  input  pahw_tag_t        tag_in,
  output logic             stall,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [ACC_W-1:0] area_out,
  output logic             ovf_out
);

  logic [ACC_W-1:0] geom_r, geom_nxt, mag, sum;
  logic             ovf_seen_r, ovf_nxt;
  logic             mag_ovf, sum_ovf;
  logic             out_v_r;
  logic [ACC_W-1:0] area_r;
  logic             out_ovf_r;
  logic             load;

  assign stall = v_in && tag_in.gend && out_v_r && !out_tready;
  assign load  = v_in && tag_in.gend && !stall;

  always_comb begin
    mag     = ring_in[ACC_W-1] ? ('0 - ring_in) : ring_in;
    mag_ovf = (ring_in == ACC_MIN);
    sum     = tag_in.hole ? (geom_r - mag) : (geom_r + mag);
    sum_ovf = tag_in.hole ? sub_ovf(geom_r, mag, sum) : add_ovf(geom_r, mag, sum);
    geom_nxt = tag_in.close ? sum : geom_r;
    ovf_nxt  = ovf_seen_r | ovf_in | (tag_in.close & (mag_ovf | sum_ovf));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r     <= '0;
      ovf_seen_r <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (v_in && !stall) begin
        if (tag_in.gend) begin
          geom_r     <= '0;
          ovf_seen_r <= 1'b0;
        end else begin
          geom_r     <= geom_nxt;
          ovf_seen_r <= ovf_nxt;
        end
      end
      if (load) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      area_r    <= tag_in.poly ? geom_nxt : '0;
      out_ovf_r <= tag_in.poly & ovf_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign area_out   = area_r;
  assign ovf_out    = out_ovf_r;

  `PAHW_ASSERT_IMP(a_stall_needs_full, stall, out_v_r, "stall with empty result register")
  `PAHW_ASSERT_NXT(a_load_shows, load, out_v_r, "loaded result not presented")
  `PAHW_ASSERT_NXT(a_nonpoly_zero, load && !tag_in.poly, (area_r == '0) && !out_ovf_r, "non-polygon result not zero")

endmodule

@@ design/polygon_area_with_holes_top.sv @@
// Top level of the streaming polygon area block (twice the area, holes subtracted).
// Depends on pahw_pkg, pahw_vertex, pahw_ring and pahw_geom.
//
//   channel | dir | tdata                    | tuser                           | tlast
//   in_     | in  | x_coord[23:0] y[47:24]   | ring_end, is_hole, is_polygon   | geom_end
//   out_    | out | area_times_two[63:0]     | overflow                        | -
//
// One vertex word is taken every cycle unless the pipeline holds; the result of a
// geom_end word passes from the input register through the products, cross terms,
// ring sum and geometry total into the result register.
// Synchronous active-low reset clears all control state and accumulators.
// The pipeline holds only when a geometry result reaches the result register
// while the previous one is still waiting on out_tready.

module polygon_area_with_holes_top import pahw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // x_coord, y_coord
  input  logic [IN_USER_W-1:0] in_tuser,   // ring_end, is_hole, is_polygon
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [ACC_W-1:0]     out_tdata,  // area_times_two
  output logic [0:0]           out_tuser   // overflow
);

  logic                         en, stall;
  logic                         v1_r;
  logic signed [COORD_BITS-1:0] x1_r, y1_r;
  pahw_tag_t                    tag1_r, tag_in;
  logic                         v2, v4;
  logic signed [PROD_W-1:0]     pa, pb, pc, pd;
  pahw_tag_t                    tag2, tag4;
  logic [ACC_W-1:0]             ring_tot;
  logic                         ring_ovf;
  logic                         ovf_bit;

  assign en        = !stall;
  assign in_tready = en;

  always_comb begin
    tag_in.start = 1'b0;
    tag_in.close = in_tuser[UB_RING_END] | in_tlast;
    tag_in.hole  = in_tuser[UB_IS_HOLE];
    tag_in.gend  = in_tlast;
    tag_in.poly  = in_tuser[UB_IS_POLY];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= coord_of(in_tdata[FIELD_W-1:0]);
      y1_r   <= coord_of(in_tdata[IN_DATA_W-1:FIELD_W]);
      tag1_r <= tag_in;
    end
  end

  pahw_vertex u_vertex (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_in    (v1_r),
    .x_in    (x1_r),
    .y_in    (y1_r),
    .tag_in  (tag1_r),
    .v_out   (v2),
    .pa_out  (pa),
    .pb_out  (pb),
    .pc_out  (pc),
    .pd_out  (pd),
    .tag_out (tag2)
  );

  pahw_ring u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (v2),
    .pa_in    (pa),
    .pb_in    (pb),
    .pc_in    (pc),
    .pd_in    (pd),
    .tag_in   (tag2),
    .v_out    (v4),
    .ring_out (ring_tot),
    .ovf_out  (ring_ovf),
    .tag_out  (tag4)
  );

  pahw_geom u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .v_in       (v4),
    .ring_in    (ring_tot),
    .ovf_in     (ring_ovf),
    .tag_in     (tag4),
    .stall      (stall),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .area_out   (out_tdata),
    .ovf_out    (ovf_bit)
  );

  assign out_tuser[0] = ovf_bit;

endmodule

@@ test/polygon_area_checker.sv @@
// Scoreboard for the polygon area block: watches both stream channels, predicts
// twice the area of each geometry and compares every result word.
// Depends on pahw_pkg.
module polygon_area_checker import pahw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [IN_USER_W-1:0] in_tuser,
  input  logic                 in_tlast,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [ACC_W-1:0]     out_tdata,
  input  logic [0:0]           out_tuser,
  output int                   fail_count,
  output int                   areas_pending
);

  typedef struct packed {
    logic [ACC_W-1:0] area;
    logic             ovf;
  } area_word_t;

  area_word_t area_q[$];

  logic signed [COORD_BITS-1:0] anchor_x, anchor_y, trail_x, trail_y;
  logic                         ring_fresh;
  logic [ACC_W-1:0]             ring_sum, geom_sum;
  logic                         wrapped;
  int                           fails = 0;
  int                           waiting = 0;

  assign fail_count    = fails;
  assign areas_pending = waiting;

  function automatic logic [ACC_W-1:0] cross_term(
      input logic signed [COORD_BITS-1:0] px, py, cx, cy);
    logic signed [ACC_W-1:0] wpx, wpy, wcx, wcy;
    wpx = px;
    wpy = py;
    wcx = cx;
    wcy = cy;
    return wpx * wcy - wcx * wpy;
  endfunction

  task automatic accumulate(inout logic [ACC_W-1:0] acc, input logic [ACC_W-1:0] term,
                            input logic minus);
    logic [ACC_W-1:0] s;
    s = minus ? acc - term : acc + term;
    // add wraps on equal signs, subtract on differing signs
    if ((acc[ACC_W-1] ^ term[ACC_W-1]) == minus && s[ACC_W-1] != acc[ACC_W-1])
      wrapped = 1'b1;
    acc = s;
  endtask

  task automatic take_vertex();
    logic signed [COORD_BITS-1:0] x, y;
    logic [ACC_W-1:0]             mag;
    area_word_t                   w;
    x = in_tdata[COORD_BITS-1:0];
    y = in_tdata[FIELD_W +: COORD_BITS];
    if (ring_fresh) begin
      anchor_x   = x;
      anchor_y   = y;
      ring_sum   = '0;
      ring_fresh = 1'b0;
    end else begin
      accumulate(ring_sum, cross_term(trail_x, trail_y, x, y), 1'b0);
    end
    trail_x = x;
    trail_y = y;
    if (in_tuser[UB_RING_END] || in_tlast) begin
      accumulate(ring_sum, cross_term(x, y, anchor_x, anchor_y), 1'b0);
      mag = ring_sum;
      if (mag[ACC_W-1]) begin
        if (mag == ACC_MIN) wrapped = 1'b1;
        mag = -mag;
      end
      accumulate(geom_sum, mag, in_tuser[UB_IS_HOLE]);
      ring_sum   = '0;
      ring_fresh = 1'b1;
    end
    if (in_tlast) begin
      w.area = in_tuser[UB_IS_POLY] ? geom_sum : '0;
      w.ovf  = in_tuser[UB_IS_POLY] ? wrapped : 1'b0;
      area_q = {area_q, w};
      waiting++;
      geom_sum   = '0;
      ring_sum   = '0;
      wrapped    = 1'b0;
      ring_fresh = 1'b1;
    end
  endtask

  task automatic check_word();
    area_word_t want;
    if (area_q.size() == 0) begin
      $error("result word with none expected: area_times_two %0d", $signed(out_tdata));
      fails++;
    end else begin
      want = area_q.pop_front();
      waiting--;
      if (out_tdata !== want.area) begin
        $error("area_times_two: expected %0d, got %0d", $signed(want.area), $signed(out_tdata));
        fails++;
      end
      if (out_tuser[0] !== want.ovf) begin
        $error("overflow: expected %0b, got %0b", want.ovf, out_tuser[0]);
        fails++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      anchor_x   = '0;
      anchor_y   = '0;
      trail_x    = '0;
      trail_y    = '0;
      ring_fresh = 1'b1;
      ring_sum   = '0;
      geom_sum   = '0;
      wrapped    = 1'b0;
      area_q.delete();
      waiting    = 0;
    end else begin
      if (in_tvalid && in_tready) take_vertex();
      if (out_tvalid && out_tready) check_word();
    end
  end

endmodule

@@ test/testbench.sv @@
// Top of the polygon area testbench: clock, reset, vertex stimulus and verdict.
// Depends on pahw_pkg, polygon_area_with_holes_top and polygon_area_checker.
module testbench;
  import pahw_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int WRAP_LAPS   = 40;
  localparam logic [COORD_BITS-1:0] C_MAX  = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] C_MIN  = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [COORD_BITS-1:0] C_NEG1 = '1;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata  = '0;
  logic [IN_USER_W-1:0] in_tuser  = '0;
  logic                 in_tlast  = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [ACC_W-1:0]     out_tdata;
  logic [0:0]           out_tuser;

  int tx_idle       = 0;
  int rx_stall      = 0;
  int vertices_sent = 0;
  int fails;
  int pending;

  polygon_area_with_holes_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  polygon_area_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fails),
    .areas_pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall);
  end

  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: return C_MIN;
          1: return C_MAX;
          2: return C_NEG1;
          default: return '0;
        endcase
      end
      1: return COORD_BITS'(int'($urandom_range(2000)) - 1000);
      default: return COORD_BITS'($urandom());
    endcase
  endfunction

  task automatic vtx(input logic [COORD_BITS-1:0] x, y,
                     input logic rend, hole, gend, poly);
    logic [IN_USER_W-1:0] user;
    user = '0;
    user[UB_RING_END] = rend;
    user[UB_IS_HOLE]  = hole;
    user[UB_IS_POLY]  = poly;
    while (tx_idle != 0 && $urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({y, x});
    in_tuser  <= user;
    in_tlast  <= gend;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    vertices_sent++;
  endtask

  // one ring wound over and over to build a large ring sum
  task automatic send_wrap_ring();
    logic [COORD_BITS-1:0] n_max;
    logic                  last;
    n_max = -C_MAX;
    for (int lap = 0; lap < WRAP_LAPS; lap++) begin
      last = (lap == WRAP_LAPS - 1);
      vtx(C_MAX, C_MAX, 1'b0, 1'b0, 1'b0, 1'b0);
      vtx(n_max, C_MAX, 1'b0, 1'b0, 1'b0, 1'b0);
      vtx(n_max, n_max, 1'b0, 1'b0, 1'b0, 1'b0);
      vtx(C_MAX, n_max, last, 1'b0, last, 1'b1);
    end
  endtask

  task automatic send_random(input int quota);
    int   stop_at, rings, nv;
    logic hole, last_r, last_g, rend;
    stop_at = vertices_sent + quota;
    while (vertices_sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        // broken sequences: marks at random
        repeat ($urandom_range(1, 6))
          vtx(pick_coord(), pick_coord(), $urandom_range(3) == 0, 1'($urandom_range(1)),
              $urandom_range(5) == 0, 1'($urandom_range(1)));
      end else begin
        rings = $urandom_range(1, 4);
        for (int r = 0; r < rings; r++) begin
          nv   = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
          hole = (r == 0) ? ($urandom_range(7) == 0) : 1'($urandom_range(1));
          for (int v = 0; v < nv; v++) begin
            last_r = (v == nv - 1);
            last_g = last_r && (r == rings - 1);
            rend   = last_r && !(last_g && $urandom_range(7) == 0);
            vtx(pick_coord(), pick_coord(), rend,
                last_r ? hole : 1'($urandom_range(1)), last_g,
                last_g ? ($urandom_range(9) != 0) : 1'($urandom_range(1)));
          end
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle  = 7;
    rx_stall = 69;
    // full-range square
    vtx('0,    '0,    1'b0, 1'b0, 1'b0, 1'b1);
    vtx(C_MAX, '0,    1'b0, 1'b0, 1'b0, 1'b0);
    vtx(C_MAX, C_MAX, 1'b0, 1'b1, 1'b0, 1'b0);
    vtx('0,    C_MAX, 1'b1, 1'b0, 1'b1, 1'b1);
    // extreme outer ring with a triangular hole
    vtx(C_MIN, C_MIN, 1'b0, 1'b0, 1'b0, 1'b0);
    vtx(C_MAX, C_MIN, 1'b0, 1'b0, 1'b0, 1'b0);
    vtx(C_MAX, C_MAX, 1'b0, 1'b0, 1'b0, 1'b0);
    vtx(C_MIN, C_MAX, 1'b1, 1'b0, 1'b0, 1'b0);
    vtx(24'd10,   24'd10,   1'b0, 1'b0, 1'b0, 1'b0);
    vtx(24'd1000, 24'd10,   1'b0, 1'b0, 1'b0, 1'b0);
    vtx(24'd10,   24'd2000, 1'b1, 1'b1, 1'b1, 1'b1);
    // lone vertex
    vtx(C_MAX, C_MIN, 1'b1, 1'b0, 1'b1, 1'b1);
    // not a polygon
    vtx(24'd5,   24'd5,   1'b0, 1'b1, 1'b0, 1'b1);
    vtx(C_NEG1,  24'd500, 1'b0, 1'b0, 1'b0, 1'b0);
    vtx(24'd700, C_NEG1,  1'b1, 1'b0, 1'b1, 1'b0);
    // clockwise ring closed by geom_end alone, marked as hole
    vtx(C_MIN, C_MIN, 1'b0, 1'b0, 1'b0, 1'b1);
    vtx(C_MIN, C_MAX, 1'b0, 1'b0, 1'b0, 1'b0);
    vtx(C_MAX, C_MIN, 1'b0, 1'b1, 1'b1, 1'b1);
    send_random(320);

    tx_idle  = 69;
    rx_stall = 7;
    send_random(320);

    tx_idle  = 0;
    rx_stall = 0;
    send_wrap_ring();
    send_random(130);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ polygon_area_with_holes_top.f @@
+incdir+design
design/pahw_pkg.sv
design/pahw_vertex.sv
design/pahw_ring.sv
design/pahw_geom.sv
design/polygon_area_with_holes_top.sv
test/polygon_area_checker.sv
test/testbench.sv
